// ===== sv/sobel_edge_magnitude_rgb_defines.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using module.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sem_pkg.sv =====
// Types, constants and arithmetic helpers for the Sobel edge magnitude block.
// No dependencies; imported by every module of the block.
package sem_pkg;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	typedef struct packed {
		logic  action;
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
	} sem_in_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
		logic  frame_end;
	} sem_out_t;

	// One channel of the 3x3 neighborhood, row-major.
	typedef chan_t [0:8] nbhd_t;

	localparam int LANE_STAGES = 7;

	typedef struct packed {
		logic [LANE_STAGES:0] en;
		logic                 in_ready;
	} pipe_ctrl_t;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam int CFG_DW = 16;
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	localparam logic [10:0] WIDTH_RESET  = 11'd1024;
	localparam logic [15:0] HEIGHT_RESET = 16'd1;

	localparam logic [21:0] SAT_LIMIT = 22'd65281;
	localparam chan_t       CHAN_MAX  = 8'd255;

	localparam int KX [0:8] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
	localparam int KY [0:8] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

	typedef struct packed {
		logic [9:0] rem;
		logic [7:0] root;
	} sq_acc_t;

	localparam sq_acc_t SQ_ZERO = '0;

	function automatic logic signed [10:0] sobel_sum(nbhd_t p, logic is_y);
		int acc;
		acc = 0;
		for (int k = 0; k < 9; k++) begin
			acc = acc + (is_y ? KY[k] : KX[k]) * int'(p[k]);
		end
		return 11'(acc);
	endfunction

	// One digit of the restoring square root: two radicand bits in, one root bit out.
	function automatic sq_acc_t sqrt_step(sq_acc_t a, logic [1:0] d);
		logic [11:0] r;
		logic [11:0] t;
		sq_acc_t     n;
		r = {a.rem, d};
		t = {2'b00, a.root, 2'b01};
		if (r >= t) begin
			n.rem  = 10'(r - t);
			n.root = {a.root[6:0], 1'b1};
		end else begin
			n.rem  = r[9:0];
			n.root = {a.root[6:0], 1'b0};
		end
		return n;
	endfunction

	function automatic sq_acc_t sqrt_two(sq_acc_t a, logic [3:0] d);
		return sqrt_step(sqrt_step(a, d[3:2]), d[1:0]);
	endfunction

endpackage

// ===== sv/sem_lane.sv =====
// One channel lane: Sobel sums, squared magnitude and a pipelined rounded square root.
// Depends on sem_pkg; stage enables come from sem_merge.
module sem_lane
	import sem_pkg::*;
(
	input  logic                 clk,
	input  logic [LANE_STAGES:0] en,
	input  nbhd_t                win,
	output chan_t                mag
);

	logic signed [10:0] gx_s2, gy_s2;
	logic signed [21:0] gx2, gy2;
	logic [21:0]        sum_c;
	logic [15:0]        rad_s3, rad_s4, rad_s5, rad_s6;
	logic               sat_s3, sat_s4, sat_s5, sat_s6, sat_s7;
	sq_acc_t            acc_s4, acc_s5, acc_s6, acc_s7;
	logic [8:0]         rounded;
	chan_t              mag_s8;

	always_comb begin
		gx2 = gx_s2 * gx_s2;
		gy2 = gy_s2 * gy_s2;
		sum_c = $unsigned(gx2) + $unsigned(gy2);
		// Round up when the remainder passes the root, i.e. s > m*m + m.
		rounded = {1'b0, acc_s7.root}
			+ 9'((acc_s7.rem > {2'b00, acc_s7.root}) ? 1 : 0);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			gx_s2 <= sobel_sum(win, 1'b0);
			gy_s2 <= sobel_sum(win, 1'b1);
		end
		if (en[2]) begin
			rad_s3 <= sum_c[15:0];
			sat_s3 <= (sum_c >= SAT_LIMIT);
		end
		if (en[3]) begin
			acc_s4 <= sqrt_two(SQ_ZERO, rad_s3[15:12]);
			rad_s4 <= rad_s3;
			sat_s4 <= sat_s3;
		end
		if (en[4]) begin
			acc_s5 <= sqrt_two(acc_s4, rad_s4[11:8]);
			rad_s5 <= rad_s4;
			sat_s5 <= sat_s4;
		end
		if (en[5]) begin
			acc_s6 <= sqrt_two(acc_s5, rad_s5[7:4]);
			rad_s6 <= rad_s5;
			sat_s6 <= sat_s5;
		end
		if (en[6]) begin
			acc_s7 <= sqrt_two(acc_s6, rad_s6[3:0]);
			sat_s7 <= sat_s6;
		end
		if (en[7]) begin
			mag_s8 <= sat_s7 ? CHAN_MAX : rounded[7:0];
		end
	end

	assign mag = mag_s8;

endmodule

// ===== sv/sem_merge.sv =====
// Pipeline flow control for the lanes and the output register that joins their results.
// Depends on sem_pkg; drives the stage enables of every sem_lane.
module sem_merge
	import sem_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_frame_end,
	output pipe_ctrl_t ctrl,
	input  chan_t      red_mag,
	input  chan_t      green_mag,
	input  chan_t      blue_mag,
	output logic       out_valid,
	input  logic       out_stall,
	output sem_out_t   out_data
);

	logic [LANE_STAGES:0] v_q, fe_q, rdy;
	logic                 out_ready;
	logic                 out_valid_q;
	sem_out_t             out_data_q;

	// A stage may load when it is empty or its content moves on this cycle.
	always_comb begin
		out_ready = !out_valid_q || !out_stall;
		rdy[LANE_STAGES] = !v_q[LANE_STAGES] || out_ready;
		for (int k = LANE_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k + 1];
		end
		ctrl.en = rdy;
		ctrl.in_ready = rdy[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k <= LANE_STAGES; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k - 1];
				end
			end
			if (out_ready) begin
				out_valid_q <= v_q[LANE_STAGES];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			fe_q[0] <= in_frame_end;
		end
		for (int k = 1; k <= LANE_STAGES; k++) begin
			if (rdy[k]) begin
				fe_q[k] <= fe_q[k - 1];
			end
		end
		if (out_ready) begin
			out_data_q.red_out   <= red_mag;
			out_data_q.green_out <= green_mag;
			out_data_q.blue_out  <= blue_mag;
			out_data_q.frame_end <= fe_q[LANE_STAGES];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// Sobel 3x3 edge magnitude on RGB words: row store, window, three lanes and merge.
// A result is registered in s1_win, the lane stages and the sem_merge output register before it is valid.
// Throughput: one pixel word per cycle when the output does not stall; a drain word holds
// in_stall while it has no result yet, and a word waits for a mismatched row-store prefetch.
// Reset: width 1024, height 1, counters and window cleared; the row store is not cleared.
`include "sobel_edge_magnitude_rgb_defines.svh"
module sobel_edge_magnitude_rgb
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sem_in_t           in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sem_out_t          out_data,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int ICW = WW + 17;
	localparam int PW  = $clog2(MAX_WIDTH + 2);

	typedef rgb_t [0:8] win_t;

	logic [10:0]    width_q;
	logic [15:0]    height_q;
	logic [CW-1:0]  col_q;
	logic [16:0]    row_q;
	logic [ICW-1:0] inc_q;
	logic [PW-1:0]  pend_q;
	win_t           win_q;
	logic           drain_busy_q;
	logic [1:0]     drain_left_q;

	logic [47:0]    row_mem [MAX_WIDTH];
	logic [47:0]    rd_mem_q;
	logic [47:0]    byp_data_q;
	logic           byp_q;
	logic [CW-1:0]  rd_tag_q;
	logic           rd_ok_q;

	win_t           s1_win;

	logic [WW-1:0]  w;
	logic [15:0]    h;
	logic [ICW-1:0] total;
	logic           full, is_drain, drain_ctx, pix_restart, drain_live;
	logic           need_feed, rd_match, can_feed, feed, has, cfg_hit;
	logic [CW-1:0]  cur_col, col_next, outcol, w_last, raddr;
	logic [16:0]    cur_row, row_next, outrow;
	logic [ICW-1:0] cur_inc;
	logic [PW-1:0]  cur_pend, pend_next;
	logic [WW-1:0]  col_inc;
	logic           wrap, shifted, top_blk, bot_blk, left_blk, right_blk, fe, end_frame;
	win_t           cur_win, nw, mwin;
	rgb_t           px, rd_a, rd_b;
	logic [47:0]    rd_word;
	pipe_ctrl_t     pipe;
	nbhd_t          s1_red, s1_green, s1_blue;
	chan_t          mag_r, mag_g, mag_b;

	always_comb begin
		if (width_q == '0) begin
			w = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(width_q);
		end
		h = (height_q == '0) ? 16'd1 : height_q;
		total = ICW'(w) * ICW'(h);
		w_last = CW'(w - WW'(1));
	end

	assign cfg_hit = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	// A pixel after a complete frame starts a new one, so it sees cleared state.
	always_comb begin
		full = inc_q >= total;
		is_drain = in_data.action == ACT_DRAIN;
		drain_ctx = drain_busy_q || is_drain;
		pix_restart = !drain_busy_q && in_valid && (in_data.action == ACT_PIXEL) && full;
		cur_col = pix_restart ? '0 : col_q;
		cur_row = pix_restart ? '0 : row_q;
		cur_inc = pix_restart ? '0 : inc_q;
		cur_pend = pix_restart ? '0 : pend_q;
		cur_win = pix_restart ? '0 : win_q;
		drain_live = full && (pend_q != '0);
		has = cur_inc >= (ICW'(w) + ICW'(1));
		need_feed = drain_busy_q || (in_valid && (!is_drain || drain_live));
		rd_match = rd_ok_q && (rd_tag_q == cur_col);
		can_feed = need_feed && rd_match && (!has || pipe.in_ready);
		feed = can_feed;
		in_stall = drain_busy_q || (need_feed && !can_feed);
	end

	assign rd_word = byp_q ? byp_data_q : rd_mem_q;
	assign rd_a = rd_word[23:0];
	assign rd_b = rd_word[47:24];

	always_comb begin
		if (drain_ctx) begin
			px = '0;
		end else begin
			px.r = in_data.red_in;
			px.g = in_data.green_in;
			px.b = in_data.blue_in;
		end
		for (int i = 0; i < 3; i++) begin
			nw[i * 3] = cur_win[i * 3 + 1];
			nw[i * 3 + 1] = cur_win[i * 3 + 2];
		end
		nw[2] = rd_b;
		nw[5] = rd_a;
		nw[8] = px;

		// The window's center trails the newest column by one; at a row start it is the
		// previous row's last pixel and the new column lies outside the frame.
		shifted = cur_col != '0;
		outrow = shifted ? cur_row - 17'd1 : cur_row - 17'd2;
		outcol = shifted ? cur_col - CW'(1) : w_last;
		top_blk = outrow == '0;
		bot_blk = outrow == (17'(h) - 17'd1);
		left_blk = outcol == '0;
		right_blk = !shifted || (outcol == w_last);
		fe = bot_blk && (outcol == w_last);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((i == 0 && top_blk) || (i == 2 && bot_blk)
						|| (j == 0 && left_blk) || (j == 2 && right_blk)) begin
					mwin[i * 3 + j] = '0;
				end else begin
					mwin[i * 3 + j] = nw[i * 3 + j];
				end
			end
		end

		col_inc = WW'(cur_col) + WW'(1);
		wrap = col_inc == w;
		col_next = wrap ? '0 : CW'(col_inc);
		row_next = wrap ? cur_row + 17'd1 : cur_row;
		pend_next = cur_pend + PW'(drain_ctx ? 0 : 1) - PW'(has ? 1 : 0);
		end_frame = feed && has && fe && drain_ctx;

		if (cfg_hit) begin
			raddr = '0;
		end else if (feed) begin
			raddr = end_frame ? '0 : col_next;
		end else if (drain_busy_q || (in_valid && is_drain)) begin
			raddr = col_q;
		end else begin
			raddr = full ? '0 : col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
			inc_q <= '0;
			pend_q <= '0;
			win_q <= '0;
			drain_busy_q <= 1'b0;
			drain_left_q <= '0;
			rd_ok_q <= 1'b0;
			rd_tag_q <= '0;
			byp_q <= 1'b0;
		end else begin
			rd_ok_q <= 1'b1;
			rd_tag_q <= raddr;
			byp_q <= feed && (raddr == cur_col);
			if (cfg_hit) begin
				if (cfg_index == REG_WIDTH) begin
					width_q <= cfg_data[10:0];
				end else begin
					height_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
				inc_q <= '0;
				pend_q <= '0;
				win_q <= '0;
				drain_busy_q <= 1'b0;
			end else if (feed) begin
				if (end_frame) begin
					col_q <= '0;
					row_q <= '0;
					inc_q <= '0;
					pend_q <= '0;
					win_q <= '0;
				end else begin
					col_q <= col_next;
					row_q <= row_next;
					inc_q <= cur_inc + ICW'(1);
					pend_q <= pend_next;
					win_q <= nw;
				end
				// A drain word may take several steps before it yields its result.
				if (drain_busy_q) begin
					if (has || drain_left_q == 2'd1) begin
						drain_busy_q <= 1'b0;
					end else begin
						drain_left_q <= drain_left_q - 2'd1;
					end
				end else if (is_drain && !has) begin
					drain_busy_q <= 1'b1;
					drain_left_q <= 2'd2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed) begin
			row_mem[cur_col] <= {rd_a, px};
		end
		rd_mem_q <= row_mem[raddr];
		byp_data_q <= {rd_a, px};
		if (pipe.en[0]) begin
			s1_win <= mwin;
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			s1_red[k] = s1_win[k].r;
			s1_green[k] = s1_win[k].g;
			s1_blue[k] = s1_win[k].b;
		end
	end

	sem_lane u_lane_r (
		.clk (clk),
		.en  (pipe.en),
		.win (s1_red),
		.mag (mag_r)
	);

	sem_lane u_lane_g (
		.clk (clk),
		.en  (pipe.en),
		.win (s1_green),
		.mag (mag_g)
	);

	sem_lane u_lane_b (
		.clk (clk),
		.en  (pipe.en),
		.win (s1_blue),
		.mag (mag_b)
	);

	sem_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (feed && has),
		.in_frame_end (fe),
		.ctrl         (pipe),
		.red_mag      (mag_r),
		.green_mag    (mag_g),
		.blue_mag     (mag_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

	`SEM_ASSERT_SAME(a_feed_tag, feed, rd_ok_q && (rd_tag_q == cur_col), "feed without row data")
	`SEM_ASSERT_SAME(a_col_range, 1'b1, 32'(col_q) < 32'(w), "column beyond frame width")
	`SEM_ASSERT_SAME(a_result_room, feed && has, pipe.in_ready, "result with no pipeline room")
	`SEM_ASSERT_NEXT(a_drain_bound, drain_busy_q && feed && !has && (drain_left_q == 2'd1),
		!drain_busy_q, "drain word ran past its step limit")

endmodule
